[src/nv2r_pkg.sv]
// Shared types, constants and color helpers for the NV21 to RGBA converter.
package nv2r_pkg;

    // Input beat: two luma samples and the chroma pair of one pixel pair.
    typedef struct packed {
        logic [7:0] luma_even;
        logic [7:0] luma_odd;
        logic [7:0] chroma_v;
        logic [7:0] chroma_u;
    } t_in_item;

    // Result beat: two packed RGBA pixels and the raster position flags.
    typedef struct packed {
        logic [31:0] rgba_even;
        logic [31:0] rgba_odd;
        logic        row_end;
        logic        frame_end;
    } t_out_item;

    // Work item handed from the front end to the color pipeline.
    typedef struct packed {
        logic [7:0] luma_even;
        logic [7:0] luma_odd;
        logic [7:0] chroma_v;
        logic [7:0] chroma_u;
        logic       row_end;
        logic       frame_end;
    } t_work;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_PER_ROW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_FRAME = 2'd1;

    // Configuration write bundle.
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    localparam logic [10:0] PPR_RESET = 11'd320;
    localparam logic [11:0] RPF_RESET = 12'd480;

    // Signed accumulator wide enough for every channel sum.
    typedef logic signed [20:0] t_acc;

    localparam logic [7:0] Y_OFFSET    = 8'd16;
    localparam logic [7:0] CHROMA_BIAS = 8'h80;
    localparam logic [7:0] ALPHA       = 8'hFF;

    localparam t_acc K_Y     = 21'sd1192;
    localparam t_acc K_RV    = 21'sd1634;
    localparam t_acc K_GV    = 21'sd833;
    localparam t_acc K_GU    = 21'sd400;
    localparam t_acc K_BU    = 21'sd2066;
    localparam t_acc ACC_MAX = 21'sd262143;

    // Luma minus the black level, floored at zero.
    function automatic logic [7:0] luma_offset(input logic [7:0] y);
        return (y >= Y_OFFSET) ? (y - Y_OFFSET) : 8'd0;
    endfunction

    // Chroma minus 128 is the sample with its top bit flipped, read as signed.
    function automatic logic signed [7:0] chroma_center(input logic [7:0] c);
        return signed'(c ^ CHROMA_BIAS);
    endfunction

    // Clamp to the 18-bit range and keep the top eight bits.
    function automatic logic [7:0] channel(input t_acc acc);
        logic [7:0] res;
        if (acc < 0) begin
            res = 8'd0;
        end else if (acc > ACC_MAX) begin
            res = 8'hFF;
        end else begin
            res = acc[17:10];
        end
        return res;
    endfunction

endpackage

[src/nv2r_fifo.sv]
// Small register FIFO used between the converter stages and at the output.
module nv2r_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/nv2r_front.sv]
// Front end: configuration, raster counters, chroma line store and classification.
module nv2r_front #(
    parameter int MAX_PAIRS = 1024,
    parameter int MAX_ROWS  = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nv2r_pkg::t_cfg_wr  i_cfg,
    input  logic               i_push,
    output logic               o_full,
    input  nv2r_pkg::t_in_item i_in_item,
    output nv2r_pkg::t_work    o_work,
    output logic               o_work_valid,
    input  logic               i_work_full
);

    localparam int CW  = $clog2(MAX_PAIRS);
    localparam int PW  = $clog2(MAX_PAIRS + 1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RPW = $clog2(MAX_ROWS + 1);

    logic [10:0]    r_ppr;
    logic [11:0]    r_rpf;
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [PW-1:0]  ppr_eff;
    logic [RPW-1:0] rpf_eff;
    logic           last_col;
    logic           last_row;
    logic           accept;
    logic           load;
    logic           cfg_hit;

    logic [15:0]    r_line [MAX_PAIRS];
    logic [15:0]    r_rd_data;
    logic           r_vld;
    logic           r_odd;
    logic [7:0]     r_luma_e;
    logic [7:0]     r_luma_o;
    logic [15:0]    r_chroma;
    logic           r_row_end;
    logic           r_frame_end;
    logic [15:0]    chroma;

    // Zero acts as one and anything above the maximum acts as the maximum.
    always_comb begin
        if (r_ppr == '0) begin
            ppr_eff = PW'(1);
        end else if (32'(r_ppr) > MAX_PAIRS) begin
            ppr_eff = PW'(MAX_PAIRS);
        end else begin
            ppr_eff = PW'(r_ppr);
        end
        if (r_rpf == '0) begin
            rpf_eff = RPW'(1);
        end else if (32'(r_rpf) > MAX_ROWS) begin
            rpf_eff = RPW'(MAX_ROWS);
        end else begin
            rpf_eff = RPW'(r_rpf);
        end
    end

    assign last_col = (PW'(r_col) + PW'(1)) >= ppr_eff;
    assign last_row = (RPW'(r_row) + RPW'(1)) >= rpf_eff;

    assign load   = !r_vld || !i_work_full;
    assign o_full = !load;
    assign accept = i_push && load;

    assign cfg_hit = i_cfg.we && ((i_cfg.index == nv2r_pkg::CFG_PAIRS_PER_ROW) ||
                                  (i_cfg.index == nv2r_pkg::CFG_ROWS_PER_FRAME));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr <= nv2r_pkg::PPR_RESET;
            r_rpf <= nv2r_pkg::RPF_RESET;
            r_col <= '0;
            r_row <= '0;
            r_vld <= 1'b0;
        end else begin
            if (i_cfg.we && (i_cfg.index == nv2r_pkg::CFG_PAIRS_PER_ROW)) begin
                r_ppr <= i_cfg.data[10:0];
            end
            if (i_cfg.we && (i_cfg.index == nv2r_pkg::CFG_ROWS_PER_FRAME)) begin
                r_rpf <= i_cfg.data;
            end
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_vld <= 1'b1;
            end else if (!i_work_full) begin
                r_vld <= 1'b0;
            end
        end
    end

    // Even rows store the chroma pair; odd rows read it back at the same column.
    always_ff @(posedge i_clk) begin
        if (accept && !r_row[0]) begin
            r_line[r_col] <= {i_in_item.chroma_v, i_in_item.chroma_u};
        end
        if (accept && r_row[0]) begin
            r_rd_data <= r_line[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_odd       <= r_row[0];
            r_luma_e    <= i_in_item.luma_even;
            r_luma_o    <= i_in_item.luma_odd;
            r_chroma    <= {i_in_item.chroma_v, i_in_item.chroma_u};
            r_row_end   <= last_col;
            r_frame_end <= last_col && last_row;
        end
    end

    assign chroma = r_odd ? r_rd_data : r_chroma;

    assign o_work_valid     = r_vld;
    assign o_work.luma_even = r_luma_e;
    assign o_work.luma_odd  = r_luma_o;
    assign o_work.chroma_v  = chroma[15:8];
    assign o_work.chroma_u  = chroma[7:0];
    assign o_work.row_end   = r_row_end;
    assign o_work.frame_end = r_frame_end;

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last_col && !cfg_hit |=> (r_col == '0))
        else $error("column counter did not wrap after the last pair of a row");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_col == '0) && (r_row == '0))
        else $error("configuration write did not restart the frame");

endmodule

[src/nv2r_back.sv]
// Back end: two-stage fixed-point color pipeline from YUV to packed RGBA.
module nv2r_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nv2r_pkg::t_work     i_work,
    input  logic                i_work_valid,
    output logic                o_work_pop,
    input  logic                i_out_full,
    output logic                o_out_push,
    output nv2r_pkg::t_out_item o_out_item
);

    logic                 adv;
    logic [7:0]           y_e;
    logic [7:0]           y_o;
    logic signed [7:0]    u;
    logic signed [7:0]    v;

    logic                 r1_vld;
    nv2r_pkg::t_acc       r1_ys_e;
    nv2r_pkg::t_acc       r1_ys_o;
    nv2r_pkg::t_acc       r1_rv;
    nv2r_pkg::t_acc       r1_gv;
    nv2r_pkg::t_acc       r1_bu;
    logic                 r1_row_end;
    logic                 r1_frame_end;

    logic                 r2_vld;
    nv2r_pkg::t_out_item  r2_item;
    nv2r_pkg::t_out_item  n2_item;

    // The whole pipeline moves together whenever the output queue has room.
    assign adv        = !i_out_full;
    assign o_work_pop = adv && i_work_valid;
    assign o_out_push = adv && r2_vld;
    assign o_out_item = r2_item;

    assign y_e = nv2r_pkg::luma_offset(i_work.luma_even);
    assign y_o = nv2r_pkg::luma_offset(i_work.luma_odd);
    assign u   = nv2r_pkg::chroma_center(i_work.chroma_u);
    assign v   = nv2r_pkg::chroma_center(i_work.chroma_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_work_valid;
            r2_vld <= r1_vld;
        end
    end

    // Stage one: constant products.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ys_e      <= nv2r_pkg::t_acc'(y_e) * nv2r_pkg::K_Y;
            r1_ys_o      <= nv2r_pkg::t_acc'(y_o) * nv2r_pkg::K_Y;
            r1_rv        <= nv2r_pkg::t_acc'(v) * nv2r_pkg::K_RV;
            r1_gv        <= nv2r_pkg::t_acc'(v) * nv2r_pkg::K_GV
                          + nv2r_pkg::t_acc'(u) * nv2r_pkg::K_GU;
            r1_bu        <= nv2r_pkg::t_acc'(u) * nv2r_pkg::K_BU;
            r1_row_end   <= i_work.row_end;
            r1_frame_end <= i_work.frame_end;
        end
    end

    // Stage two: sums, clamping and packing.
    always_comb begin
        n2_item.rgba_even = {nv2r_pkg::ALPHA,
                             nv2r_pkg::channel(r1_ys_e + r1_bu),
                             nv2r_pkg::channel(r1_ys_e - r1_gv),
                             nv2r_pkg::channel(r1_ys_e + r1_rv)};
        n2_item.rgba_odd  = {nv2r_pkg::ALPHA,
                             nv2r_pkg::channel(r1_ys_o + r1_bu),
                             nv2r_pkg::channel(r1_ys_o - r1_gv),
                             nv2r_pkg::channel(r1_ys_o + r1_rv)};
        n2_item.row_end   = r1_row_end;
        n2_item.frame_end = r1_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_item <= n2_item;
        end
    end

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_work_pop |-> !i_out_full)
        else $error("work item taken while the output queue is full");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && i_out_full |=> r2_vld && $stable(r2_item))
        else $error("finished result lost while the output queue was full");

endmodule

[src/nv21_to_rgba_converter_core.sv]
// Top level of the NV21 to RGBA converter: front end, work queue, color pipeline, output queue.
// A pair passes through the front-end register, the work queue, the color pipeline and the output queue in turn.
// Throughput: one pixel pair per clock while the output queue has room, set by the single-port
// chroma line store and the two-stage color pipeline that both take a new pair every cycle.
// The output queue absorbs four results, so a stalled consumer does not drop beats.
// Reset is synchronous and active low; it clears the counters, queues and valid flags
// and loads 320 pairs per row and 480 rows per frame; the line store is not cleared.
module nv21_to_rgba_converter_core #(
    parameter int MAX_PAIRS = 1024,
    parameter int MAX_ROWS  = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input queue side: a beat is taken when push is high and full is low.
    input  logic                              push,
    output logic                              full,
    input  nv2r_pkg::t_in_item                i_in_item,
    // Result queue side: the oldest result is shown while empty is low.
    output logic                              empty,
    input  logic                              pop,
    output nv2r_pkg::t_out_item               o_out_item,
    // Configuration writes: the user must write only while the converter is idle; the block does not enforce it.
    input  logic                              i_cfg_we,
    input  logic [nv2r_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nv2r_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int WORK_W = $bits(nv2r_pkg::t_work);
    localparam int OUT_W  = $bits(nv2r_pkg::t_out_item);

    nv2r_pkg::t_cfg_wr   cfg;
    nv2r_pkg::t_work     front_work;
    logic                front_valid;
    logic                work_full;
    nv2r_pkg::t_work     queued_work;
    logic                work_empty;
    logic                work_pop;
    logic                out_full;
    logic                out_push;
    nv2r_pkg::t_out_item back_item;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // The front end tracks the raster position and resolves chroma for odd rows.
    nv2r_front #(
        .MAX_PAIRS (MAX_PAIRS),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (push),
        .o_full       (full),
        .i_in_item    (i_in_item),
        .o_work       (front_work),
        .o_work_valid (front_valid),
        .i_work_full  (work_full)
    );

    // The work queue lets the front end keep accepting while the pipeline stalls.
    nv2r_fifo #(
        .W     (WORK_W),
        .DEPTH (4)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_work),
        .o_full  (work_full),
        .i_pop   (work_pop),
        .o_data  (queued_work),
        .o_empty (work_empty)
    );

    // The back end does the fixed-point color math for both pixels of a pair.
    nv2r_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (queued_work),
        .i_work_valid (!work_empty),
        .o_work_pop   (work_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_out_item   (back_item)
    );

    // The output queue presents the oldest finished result to the consumer.
    nv2r_fifo #(
        .W     (OUT_W),
        .DEPTH (4)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

[dv/tb_nv21_to_rgba_converter_core.sv]
// Self-checking testbench for the NV21 to RGBA converter core.
module tb_nv21_to_rgba_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Line store depth and frame height limit of the block as instantiated.
    localparam int unsigned LINE_PAIRS = 1024;
    localparam int unsigned FRAME_ROWS = 2048;

    // Index that maps to no register; a write there must change nothing.
    localparam logic [nv2r_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    // The watchdog fails the run once the cycle counter reaches this limit.
    localparam int unsigned CYCLE_LIMIT = 40000;
    localparam int unsigned RANDOM_BEATS = 90;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    nv2r_pkg::t_in_item              i_in_item = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    nv2r_pkg::t_out_item             o_out_item;
    logic                            i_cfg_we = 1'b0;
    logic [nv2r_pkg::CFG_IDX_W-1:0]  i_cfg_index = nv2r_pkg::CFG_PAIRS_PER_ROW;
    logic [nv2r_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    nv21_to_rgba_converter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the block's state: register values as written, the raster
    // position, and the chroma line that odd rows read back.
    logic [10:0]  pairs_reg = 11'd320;
    logic [11:0]  rows_reg = 12'd480;
    int unsigned  pair_col = 0;
    int unsigned  pair_row = 0;
    logic [15:0]  uv_line [LINE_PAIRS];

    // Expected pixel pairs in the order the block must return them.
    nv2r_pkg::t_out_item pixel_queue [$];
    int unsigned  mismatches = 0;
    int unsigned  cycles = 0;
    int unsigned  beats_sent = 0;

    // While set, neither side inserts idle cycles.
    bit           calm = 1'b0;

    // Clamp a fixed-point channel sum to 18 bits and keep its top eight bits.
    function automatic logic [7:0] channel_byte(input int acc);
        logic [31:0] bits;
        if (acc < 0) begin
            return 8'd0;
        end
        if (acc > 262143) begin
            return 8'hFF;
        end
        bits = acc;
        return bits[17:10];
    endfunction

    // One pixel from its luma and the centered chroma pair, alpha in the top byte.
    function automatic logic [31:0] pixel_rgba(input logic [7:0] y, input int u, input int v);
        int ys;
        ys = int'(y) - 16;
        if (ys < 0) begin
            ys = 0;
        end
        ys = 1192 * ys;
        return {8'hFF, channel_byte(ys + 2066 * u),
                channel_byte(ys - 833 * v - 400 * u), channel_byte(ys + 1634 * v)};
    endfunction

    // Effective frame size: zero acts as one and oversize acts as the maximum.
    function automatic int unsigned limit_size(input int unsigned val, input int unsigned maxv);
        if (val == 0) begin
            return 1;
        end
        return (val > maxv) ? maxv : val;
    endfunction

    // Convert one accepted pair and advance the raster position.
    function automatic nv2r_pkg::t_out_item convert_pair(input nv2r_pkg::t_in_item beat);
        nv2r_pkg::t_out_item res;
        int unsigned ppr;
        int unsigned rpf;
        logic [15:0] uv;
        bit          last_col;
        bit          last_row;
        ppr = limit_size(pairs_reg, LINE_PAIRS);
        rpf = limit_size(rows_reg, FRAME_ROWS);
        if (pair_row[0] == 1'b0) begin
            uv = {beat.chroma_v, beat.chroma_u};
            uv_line[pair_col % LINE_PAIRS] = uv;
        end else begin
            uv = uv_line[pair_col % LINE_PAIRS];
        end
        last_col = (pair_col + 1) >= ppr;
        last_row = (pair_row + 1) >= rpf;
        res.rgba_even = pixel_rgba(beat.luma_even, int'(uv[7:0]) - 128, int'(uv[15:8]) - 128);
        res.rgba_odd  = pixel_rgba(beat.luma_odd, int'(uv[7:0]) - 128, int'(uv[15:8]) - 128);
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;
        if (last_col) begin
            pair_col = 0;
            pair_row = last_row ? 0 : pair_row + 1;
        end else begin
            pair_col++;
        end
        return res;
    endfunction

    // Random byte that lands on a boundary value now and then.
    function automatic logic [7:0] sample_byte();
        logic [7:0] picks [4] = '{8'd0, 8'd255, 8'd16, 8'd128};
        if ($urandom_range(7) == 0) begin
            return picks[$urandom_range(3)];
        end
        return 8'($urandom());
    endfunction

    function automatic nv2r_pkg::t_in_item random_pair();
        nv2r_pkg::t_in_item beat;
        beat.luma_even = sample_byte();
        beat.luma_odd  = sample_byte();
        beat.chroma_v  = sample_byte();
        beat.chroma_u  = sample_byte();
        return beat;
    endfunction

    // Offer one beat and hold it until the block takes it. The expected result
    // is computed at the edge that accepts the beat, so the mirror advances in
    // exactly the block's order. Push stays high afterwards so that back-to-back
    // beats need no gap.
    task automatic send_pair(input nv2r_pkg::t_in_item beat);
        while (!calm && $urandom_range(99) < 24) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= beat;
        do begin
            @(posedge i_clk);
        end while (full);
        pixel_queue.push_back(convert_pair(beat));
        beats_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) begin
            send_pair(random_pair());
        end
    endtask

    // Stop offering beats and wait until every expected pair has come out.
    task automatic drain();
        push <= 1'b0;
        while (pixel_queue.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write; the block must be idle when this is called.
    task automatic write_reg(input logic [nv2r_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nv2r_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nv2r_pkg::CFG_PAIRS_PER_ROW: begin
                pairs_reg = val[10:0];
                pair_col  = 0;
                pair_row  = 0;
            end
            nv2r_pkg::CFG_ROWS_PER_FRAME: begin
                rows_reg = val;
                pair_col = 0;
                pair_row = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_frame(input logic [nv2r_pkg::CFG_DATA_W-1:0] ppr,
                             input logic [nv2r_pkg::CFG_DATA_W-1:0] rpf);
        drain();
        write_reg(nv2r_pkg::CFG_PAIRS_PER_ROW, ppr);
        write_reg(nv2r_pkg::CFG_ROWS_PER_FRAME, rpf);
    endtask

    // Reset values: a handful of even-row pairs with luma and chroma extremes.
    task automatic test_reset_defaults();
        logic [7:0] lumas [6][2] = '{'{8'd0, 8'd255}, '{8'd15, 8'd16}, '{8'd17, 8'd235},
                                     '{8'd255, 8'd0}, '{8'd16, 8'd16}, '{8'd128, 8'd200}};
        logic [7:0] chromas [6][2] = '{'{8'd128, 8'd128}, '{8'd0, 8'd0}, '{8'd255, 8'd255},
                                       '{8'd0, 8'd255}, '{8'd255, 8'd0}, '{8'd90, 8'd240}};
        for (int k = 0; k < 6; k++) begin
            send_pair(nv2r_pkg::t_in_item'{lumas[k][0], lumas[k][1],
                                           chromas[k][0], chromas[k][1]});
        end
    endtask

    // A tiny frame of odd height: the chroma of row 0 is reused on row 1 while
    // the chroma fields sent there are junk, row 2 stores chroma nobody reads,
    // and the frame then wraps to a fresh row 0.
    task automatic test_small_frame();
        logic [7:0] uvs [4][2] = '{'{8'd0, 8'd0}, '{8'd255, 8'd255},
                                   '{8'd0, 8'd255}, '{8'd255, 8'd0}};
        logic [7:0] ys [4][2] = '{'{8'd255, 8'd255}, '{8'd0, 8'd16},
                                  '{8'd235, 8'd17}, '{8'd255, 8'd0}};
        set_frame(12'd4, 12'd3);
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 4; k++) begin
                if (r == 1) begin
                    send_pair(nv2r_pkg::t_in_item'{ys[k][0], ys[k][1],
                                                   sample_byte(), sample_byte()});
                end else begin
                    send_pair(nv2r_pkg::t_in_item'{ys[3-k][0], ys[k][1],
                                                   uvs[k][0], uvs[k][1]});
                end
            end
        end
        send_random(2);
    endtask

    // Register values at and beyond their limits, including bits above the
    // field width and zero, each followed by a run of random pairs.
    task automatic test_register_limits();
        logic [nv2r_pkg::CFG_DATA_W-1:0] pprs [6] = '{12'd0, 12'd1, 12'h800,
                                                      12'd2, 12'd3, 12'hFFF};
        logic [nv2r_pkg::CFG_DATA_W-1:0] rpfs [6] = '{12'd0, 12'd1, 12'd7,
                                                      12'h801, 12'hFFF, 12'd2};
        for (int k = 0; k < 6; k++) begin
            set_frame(pprs[k], rpfs[k]);
            send_random((k == 5) ? 40 : 24);
        end
    endtask

    // A write to an unused index leaves the frame position alone; a real write
    // in the middle of a row restarts the frame on an even row.
    task automatic test_mid_frame_writes();
        set_frame(12'd3, 12'd4);
        send_random(5);
        drain();
        write_reg(CFG_SPARE_IDX, 12'hFFF);
        send_random(8);
        drain();
        write_reg(nv2r_pkg::CFG_ROWS_PER_FRAME, 12'd5);
        send_random(10);
        drain();
        write_reg(nv2r_pkg::CFG_PAIRS_PER_ROW, 12'd2);
        send_random(12);
    endtask

    // A wide row: the odd row reads every entry that the even row stored,
    // and the frame then wraps into a new even row.
    task automatic test_wide_row();
        set_frame(12'd48, 12'd2);
        send_random(48 * 2 + 4);
    endtask

    // A tall frame of odd height with one pair per row, so every beat ends a
    // row and the frame end lands on the last, even row.
    task automatic test_tall_frame();
        set_frame(12'd1, 12'd33);
        send_random(33 + 3);
    endtask

    // Mostly whole frames of small random sizes with random content; the
    // leftover partial frame before each rewrite makes broken sequences.
    task automatic test_random_frames();
        int unsigned start;
        int unsigned ppr;
        int unsigned rpf;
        int unsigned count;
        int unsigned sel;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                ppr = $urandom_range(1, 6);
            end else if (sel < 95) begin
                ppr = $urandom_range(7, 40);
            end else begin
                ppr = $urandom_range(41, 100);
            end
            rpf = $urandom_range(1, 7);
            count = ppr * rpf * $urandom_range(1, 2) + $urandom_range(0, 2 * ppr);
            if (count > 48) begin
                count = 48;
            end
            set_frame(12'(ppr), 12'(rpf));
            for (int k = 0; k < count; k++) begin
                // One long stretch in the middle runs with no idling on either side.
                calm = (beats_sent - start >= 20) && (beats_sent - start < 80);
                send_pair(random_pair());
            end
        end
        calm = 1'b0;
    endtask

    // Result side: pop at random and compare each popped pair with the oldest
    // expectation. Pop and the outputs are read before this edge updates them.
    always @(posedge i_clk) begin
        nv2r_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t: result expected none actual %h", $time, o_out_item);
                mismatches++;
            end else begin
                want = pixel_queue.pop_front();
                if (o_out_item.rgba_even !== want.rgba_even) begin
                    $display("%0t: rgba_even expected %h actual %h",
                             $time, want.rgba_even, o_out_item.rgba_even);
                    mismatches++;
                end
                if (o_out_item.rgba_odd !== want.rgba_odd) begin
                    $display("%0t: rgba_odd expected %h actual %h",
                             $time, want.rgba_odd, o_out_item.rgba_odd);
                    mismatches++;
                end
                if (o_out_item.row_end !== want.row_end) begin
                    $display("%0t: row_end expected %b actual %b",
                             $time, want.row_end, o_out_item.row_end);
                    mismatches++;
                end
                if (o_out_item.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b",
                             $time, want.frame_end, o_out_item.frame_end);
                    mismatches++;
                end
            end
        end
        pop <= calm || ($urandom_range(99) >= 24);
    end

    // Watchdog for a block that stops moving.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_nv21_to_rgba_converter_core failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_small_frame();
        test_register_limits();
        test_mid_frame_writes();
        test_wide_row();
        test_tall_frame();
        test_random_frames();

        // Everything sent has come back; give stray beats time to show up.
        drain();
        repeat (12) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_nv21_to_rgba_converter_core passed");
        end else begin
            $display("tb_nv21_to_rgba_converter_core failed");
        end
        $finish;
    end

endmodule

[files.f]
src/nv2r_pkg.sv
src/nv2r_fifo.sv
src/nv2r_front.sv
src/nv2r_back.sv
src/nv21_to_rgba_converter_core.sv
dv/tb_nv21_to_rgba_converter_core.sv
